// ----- hdl/iaid_pkg.sv -----
package iaid_pkg;

    localparam int WORD_W = 32;
    localparam int POS_W  = 5;
    localparam int CNT_W  = 5;
    localparam int CAP_W  = 5;
    // Wide enough for any cell index and for the array depth itself.
    localparam int IDX_W  = 7;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_POS = 2'd2
    } t_status;

    typedef struct packed {
        t_op                       operation;
        logic [POS_W-1:0]          position;
        logic signed [WORD_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        t_status                   status;
        logic signed [WORD_W-1:0]  data;
        logic [CNT_W-1:0]          count;
    } t_out_item;

    // Broadcast from the control logic to every cell of the row.
    typedef struct packed {
        logic                      ins;
        logic                      del;
        logic [POS_W-1:0]          pos;
        logic [WORD_W-1:0]         value;
    } t_cell_ctrl;

endpackage

// ----- hdl/iaid_cell.sv -----
module iaid_cell
    import iaid_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic                i_clk,
    input  t_cell_ctrl          i_ctrl,
    input  logic [WORD_W-1:0]   i_prev_word,
    input  logic [WORD_W-1:0]   i_next_word,
    output logic [WORD_W-1:0]   o_word
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;
    logic [IDX_W-1:0]  pos_ext;

    assign pos_ext = {{(IDX_W-POS_W){1'b0}}, i_ctrl.pos};

    // On insert, cells above the position take their lower neighbor and the
    // cell at the position takes the new word. On delete, cells at and above
    // the position take their upper neighbor.
    always_comb begin
        n_word = r_word;
        if (i_ctrl.ins) begin
            if (MY_IDX > pos_ext) begin
                n_word = i_prev_word;
            end else if (MY_IDX == pos_ext) begin
                n_word = i_ctrl.value;
            end
        end else if (i_ctrl.del) begin
            if (MY_IDX >= pos_ext) begin
                n_word = i_next_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// ----- hdl/indexed_array_insert_delete_core.sv -----
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-------------------------
// command  | in        | start high and busy low    | i_item (t_in_item)
// result   | out       | o_done high for one cycle  | o_result (t_out_item)
// config   | in        | i_cfg_we high              | i_cfg_wdata (capacity)
//
// Operations never wait on one another: the row of cells shifts all stored
// words at once, so busy stays low and a new item may be started in every
// cycle. The result of an item accepted at one edge is shown, with o_done,
// during the following cycle. Reset is synchronous and active low; it empties
// the array and sets capacity to 16. The receiver cannot stall the result.
module indexed_array_insert_delete_core
    import iaid_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  t_in_item            i_item,
    output logic                o_done,
    output t_out_item           o_result,
    input  logic                i_cfg_we,
    input  logic [CAP_W-1:0]    i_cfg_wdata
);

    localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(DEPTH);

    // Control state: element count, capacity register and result strobe.
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CAP_W-1:0]  r_capacity;
    logic              r_done;
    t_out_item         r_result;
    t_out_item         n_result;

    logic              accept;
    logic [IDX_W-1:0]  limit;
    logic [IDX_W-1:0]  cap_ext;
    logic [IDX_W-1:0]  cnt_ext;
    logic              full;
    logic              pos_le_cnt;
    logic              pos_lt_cnt;
    logic [WORD_W-1:0] rd_word;
    t_cell_ctrl        ctrl;

    logic [WORD_W-1:0] words [DEPTH];

    // The array never holds more than its depth, whatever capacity says.
    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign cap_ext = {{(IDX_W-CAP_W){1'b0}}, r_capacity};
    assign cnt_ext = {{(IDX_W-CNT_W){1'b0}}, r_count};
    assign limit   = (cap_ext < DEPTH_IDX) ? cap_ext : DEPTH_IDX;
    assign full    = (cnt_ext >= limit);
    assign pos_le_cnt = (i_item.position <= r_count);
    assign pos_lt_cnt = (i_item.position < r_count);

    // Read port of the row: the position selects one cell. A valid read or
    // delete position is always below the count and so inside the row.
    always_comb begin
        rd_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if ({{(IDX_W-POS_W){1'b0}}, i_item.position} == IDX_W'(i)) begin
                rd_word = words[i];
            end
        end
    end

    // Decode the item into the cell commands and the result. An append is an
    // insert at the current count. Fullness is checked before the position.
    always_comb begin
        ctrl           = '0;
        ctrl.pos       = i_item.position;
        ctrl.value     = i_item.value;
        n_count        = r_count;
        n_result       = '0;
        n_result.status = ST_OK;
        case (i_item.operation)
            OP_APPEND: begin
                ctrl.pos = r_count;
                if (full) begin
                    n_result.status = ST_FULL;
                end else begin
                    ctrl.ins = accept;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            OP_INSERT: begin
                if (full) begin
                    n_result.status = ST_FULL;
                end else if (!pos_le_cnt) begin
                    n_result.status = ST_BAD_POS;
                end else begin
                    ctrl.ins = accept;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            OP_DELETE: begin
                if (!pos_lt_cnt) begin
                    n_result.status = ST_BAD_POS;
                end else begin
                    ctrl.del      = accept;
                    n_result.data = rd_word;
                    n_count       = r_count - CNT_W'(1);
                end
            end
            OP_READ: begin
                if (!pos_lt_cnt) begin
                    n_result.status = ST_BAD_POS;
                end else begin
                    n_result.data = rd_word;
                end
            end
            default: begin
                n_result.status = ST_BAD_POS;
            end
        endcase
        n_result.count = n_count;
    end

    // The row of cells. The first cell has no lower neighbor and the last
    // cell refills itself on delete; that word lies beyond the count.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_W-1:0] prev_word;
        logic [WORD_W-1:0] next_word;

        if (g == 0) begin : g_first
            assign prev_word = '0;
        end else begin : g_mid_lo
            assign prev_word = words[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign next_word = words[g];
        end else begin : g_mid_hi
            assign next_word = words[g+1];
        end

        iaid_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_prev_word (prev_word),
            .i_next_word (next_word),
            .o_word      (words[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_capacity <= CAP_W'(16);
            r_done     <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
        end
    end

    // Result payload needs no reset; the strobe qualifies it.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
